// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define KL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define KL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define KL_ASSERT_SAME(label, clk, rst, ante, cons)
`define KL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/kl_pkg.sv =====
// ----------------------------------------------------------------------------
// kl_pkg
// Types, constants and round functions shared by the KeeLoq cipher block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kl_pkg;

   localparam int RoundsTotal   = 528;
   localparam int RoundsPerCell = 8;
   localparam int NumCells      = RoundsTotal / RoundsPerCell;

   localparam int KeyWidth      = 64;
   localparam int WordWidth     = 32;
   localparam int LearnWidth    = 4;
   localparam int CsrIndexWidth = 4;

   localparam logic [31:0] KlNlf       = 32'h3A5C742E;
   localparam logic [31:0] FixMask     = 32'h0FFFFFFF;
   localparam logic [31:0] PrefixLow   = 32'h20000000;
   localparam logic [31:0] PrefixHigh  = 32'h60000000;
   localparam logic [31:0] MixUpMask   = 32'hF000F000;
   localparam logic [31:0] MixDownMask = 32'h0F000F00;
   localparam logic [31:0] MixKeepMask = 32'h00FF00FF;
   localparam int          DecKeyBase  = 15;

   // func codes
   typedef enum logic [1:0] {
      FuncEncrypt = 2'd0,
      FuncDecrypt = 2'd1,
      FuncDerive  = 2'd2
   } kl_func_type;

   // learning types
   localparam logic [LearnWidth-1:0] LearnNormal  = 4'd1;
   localparam logic [LearnWidth-1:0] LearnSecure  = 4'd2;
   localparam logic [LearnWidth-1:0] LearnXor1    = 4'd3;
   localparam logic [LearnWidth-1:0] LearnSerial1 = 4'd4;
   localparam logic [LearnWidth-1:0] LearnSerial2 = 4'd5;
   localparam logic [LearnWidth-1:0] LearnSerial3 = 4'd6;
   localparam logic [LearnWidth-1:0] LearnAerf    = 4'd7;
   localparam logic [LearnWidth-1:0] LearnErreka  = 4'd8;
   localparam logic [LearnWidth-1:0] LearnPujol   = 4'd9;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CsrCipherKey    = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CsrLearningType = 4'd1;

   // what a cell does with its lanes
   typedef enum logic [1:0] {
      ModeEncrypt,
      ModeDecrypt,
      ModeDual,
      ModeBypass
   } kl_mode_type;

   typedef struct packed {
      logic                 valid;
      kl_mode_type          mode;
      logic                 swap;
      logic [WordWidth-1:0] lane_a;
      logic [WordWidth-1:0] lane_b;
   } kl_stage_type;

   function automatic logic [5:0] kl_enc_key_idx(input int round);
      return 6'(round);
   endfunction

   // (15 - round) mod 64, two's complement truncation
   function automatic logic [5:0] kl_dec_key_idx(input int round);
      return 6'(DecKeyBase - round);
   endfunction

   function automatic logic [WordWidth-1:0] kl_enc_round(input logic [WordWidth-1:0] x,
                                                         input logic kb);
      logic nb;
      nb = x[0] ^ x[16] ^ kb ^ KlNlf[{x[31], x[26], x[20], x[9], x[1]}];
      return {nb, x[31:1]};
   endfunction

   function automatic logic [WordWidth-1:0] kl_dec_round(input logic [WordWidth-1:0] x,
                                                         input logic kb);
      logic nb;
      nb = x[31] ^ x[15] ^ kb ^ KlNlf[{x[30], x[25], x[19], x[8], x[0]}];
      return {x[30:0], nb};
   endfunction

   function automatic logic [WordWidth-1:0] kl_swap_halves(input logic [WordWidth-1:0] w);
      return {w[15:0], w[31:16]};
   endfunction

endpackage

// ===== rtl/kl_if.sv =====
// ----------------------------------------------------------------------------
// kl_if
// Request, response and register write channels of the KeeLoq block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kl_req_if;
   import kl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic [WordWidth-1:0] data_word;
   logic [WordWidth-1:0] seed_word;

   modport source (output valid, func, data_word, seed_word, input ready);
   modport sink   (input valid, func, data_word, seed_word, output ready);
endinterface

interface kl_rsp_if;
   import kl_pkg::*;
   logic                valid;
   logic                ready;
   logic [KeyWidth-1:0] result_word;

   modport source (output valid, result_word, input ready);
   modport sink   (input valid, result_word, output ready);
endinterface

interface kl_csr_if;
   import kl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] reg_index;
   logic [KeyWidth-1:0]      wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/kl_round_cell.sv =====
// ----------------------------------------------------------------------------
// kl_round_cell
// One link of the round chain: eight KeeLoq rounds on two lanes, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kl_round_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [63:0]          cipher_key,
   input  kl_pkg::kl_stage_type stage_i,
   output kl_pkg::kl_stage_type stage_o
);
   import kl_pkg::*;

   kl_stage_type stage_in;
   kl_stage_type stage_ff;

   always_comb begin
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] b;
      int                   rnd;
      a = stage_i.lane_a;
      b = stage_i.lane_b;
      for (int j = 0; j < RoundsPerCell; j++) begin
         rnd = STAGE * RoundsPerCell + j;
         if (stage_i.mode == ModeEncrypt) begin
            a = kl_enc_round(a, cipher_key[kl_enc_key_idx(rnd)]);
         end else if (stage_i.mode != ModeBypass) begin
            a = kl_dec_round(a, cipher_key[kl_dec_key_idx(rnd)]);
         end
         // lane b only carries weight in dual decrypt
         if (stage_i.mode == ModeDual) begin
            b = kl_dec_round(b, cipher_key[kl_dec_key_idx(rnd)]);
         end
      end
      stage_in        = stage_i;
      stage_in.lane_a = a;
      stage_in.lane_b = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

// ===== rtl/kl_rsp_stage.sv =====
// ----------------------------------------------------------------------------
// kl_rsp_stage
// Output register with a one-beat skid slot; freezes the chain when full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kl_rsp_stage (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_word,
   output logic        in_ready,
   kl_rsp_if.source    rsp_if
);
   import kl_pkg::*;

   logic                out_valid_ff;
   logic                out_valid_in;
   logic [KeyWidth-1:0] out_word_ff;
   logic [KeyWidth-1:0] out_word_in;
   logic                skid_valid_ff;
   logic                skid_valid_in;
   logic [KeyWidth-1:0] skid_word_ff;
   logic [KeyWidth-1:0] skid_word_in;
   logic                take;
   logic                out_free;

   assign in_ready = !skid_valid_ff;
   assign take     = in_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_if.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            out_word_in  = in_word;
         end
      end else if (take) begin
         // park the beat until the sink drains
         skid_valid_in = 1'b1;
         skid_word_in  = in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.result_word = out_word_ff;

endmodule

// ===== rtl/keeloq_cipher_key_derive.sv =====
// ----------------------------------------------------------------------------
// keeloq_cipher_key_derive
// Pipeline: a request beat, once taken, passes one entry register, then
//   66 round cells of 8 rounds each, then one output register.
// Throughput: one beat per cycle; the round chain freezes only while the
//   output skid slot is occupied.
// Reset: synchronous, clears every valid flag and both registers to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module keeloq_cipher_key_derive (
   input  logic     clock,
   input  logic     reset,
   kl_req_if.sink   req_if,
   kl_rsp_if.source rsp_if,
   kl_csr_if.sink   csr_if
);
   import kl_pkg::*;

   logic [KeyWidth-1:0]   key_ff;
   logic [LearnWidth-1:0] learn_ff;
   logic                  adv;
   kl_stage_type          entry_in;
   kl_stage_type          chain [NumCells+1];
   kl_stage_type          tail;
   logic [KeyWidth-1:0]   tail_word;

   // register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         learn_ff <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.reg_index)
            CsrCipherKey:    key_ff   <= csr_if.wdata;
            CsrLearningType: learn_ff <= csr_if.wdata[LearnWidth-1:0];
            default: ;
         endcase
      end
   end

   // entry: pick lane contents and mode
   always_comb begin
      logic [WordWidth-1:0] fix;
      logic [WordWidth-1:0] mix;
      logic [KeyWidth-1:0]  splice;
      fix = req_if.data_word & FixMask;
      mix = ((req_if.seed_word >> 4) & MixDownMask) |
            ((req_if.seed_word << 4) & MixUpMask) |
            (req_if.seed_word & MixKeepMask);
      splice = key_ff;
      entry_in        = '0;
      entry_in.valid  = req_if.valid;
      entry_in.mode   = ModeBypass;
      case (req_if.func)
         FuncEncrypt: begin
            entry_in.mode   = ModeEncrypt;
            entry_in.lane_a = req_if.data_word;
         end
         FuncDecrypt: begin
            entry_in.mode   = ModeDecrypt;
            entry_in.lane_a = req_if.data_word;
         end
         FuncDerive: begin
            case (learn_ff) inside
               LearnNormal, LearnAerf, LearnPujol: begin
                  entry_in.mode   = ModeDual;
                  entry_in.swap   = (learn_ff == LearnPujol);
                  entry_in.lane_a = fix | PrefixLow;
                  entry_in.lane_b = fix | PrefixHigh;
               end
               LearnSecure: begin
                  entry_in.mode   = ModeDual;
                  entry_in.lane_a = req_if.seed_word;
                  entry_in.lane_b = fix;
               end
               LearnErreka: begin
                  entry_in.mode   = ModeDual;
                  entry_in.lane_a = fix | PrefixLow;
                  entry_in.lane_b = mix | PrefixHigh;
               end
               LearnXor1: begin
                  splice = {fix, fix} ^ key_ff;
               end
               LearnSerial1: begin
                  splice = {req_if.data_word[23:0],
                            req_if.data_word[7:0] + req_if.data_word[15:8],
                            key_ff[31:0]};
               end
               LearnSerial2: begin
                  splice = {req_if.data_word[7:0], req_if.data_word[15:8],
                            req_if.data_word[23:16], req_if.data_word[31:24],
                            key_ff[31:0]};
               end
               LearnSerial3: begin
                  splice = {key_ff[63:24], req_if.data_word[23:0]};
               end
               default: ;
            endcase
            if (entry_in.mode == ModeBypass) begin
               entry_in.lane_a = splice[31:0];
               entry_in.lane_b = splice[63:32];
            end
         end
         default: ;  // unused code: bypass zeros
      endcase
   end

   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].valid <= 1'b0;
      end else if (adv) begin
         chain[0] <= entry_in;
      end
   end

   for (genvar c = 0; c < NumCells; c++) begin : g_cell
      kl_round_cell #(
         .STAGE(c)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (adv),
         .cipher_key (key_ff),
         .stage_i    (chain[c]),
         .stage_o    (chain[c+1])
      );
   end

   assign tail = chain[NumCells];

   always_comb begin
      case (tail.mode)
         ModeEncrypt, ModeDecrypt: tail_word = {32'd0, tail.lane_a};
         ModeDual: begin
            if (tail.swap) begin
               tail_word = {kl_swap_halves(tail.lane_b), kl_swap_halves(tail.lane_a)};
            end else begin
               tail_word = {tail.lane_b, tail.lane_a};
            end
         end
         default: tail_word = {tail.lane_b, tail.lane_a};
      endcase
   end

   kl_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (tail.valid),
      .in_word  (tail_word),
      .in_ready (adv),
      .rsp_if   (rsp_if)
   );

   `KL_ASSERT_NEXT(a_accept_loads_entry, clock, reset, req_if.valid && req_if.ready, chain[0].valid)
   `KL_ASSERT_NEXT(a_freeze_holds_tail, clock, reset, !adv, $stable(tail.valid) && $stable(tail_word))
   `KL_ASSERT_NEXT(a_handoff_shows_rsp, clock, reset, tail.valid && adv, rsp_if.valid)
   `KL_ASSERT_SAME(a_freeze_means_out_full, clock, reset, !adv, rsp_if.valid)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the KeeLoq cipher and key derivation block. Encrypt, decrypt and
// derive requests go in under every learning type and several keys. Each
// response beat is compared with a locally computed result word, in order.
// ----------------------------------------------------------------------------

module testbench;
   import kl_pkg::*;

   localparam logic [1:0]               FuncUnused    = 2'd3;
   localparam logic [CsrIndexWidth-1:0] CsrNoRegister = 4'd15;
   localparam int                       HoldOffCycles = 300;
   localparam int                       MaxPrinted    = 40;

   typedef struct {
      logic [1:0]           func;
      logic [WordWidth-1:0] data_word;
      logic [WordWidth-1:0] seed_word;
   } request_item_type;

   logic clock;
   logic reset;

   kl_req_if req_if ();
   kl_rsp_if rsp_if ();
   kl_csr_if csr_if ();

   keeloq_cipher_key_derive u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // local copy of the register file
   logic [KeyWidth-1:0]   key_setting;
   logic [LearnWidth-1:0] learn_setting;

   request_item_type    requests_to_send[$];
   logic [KeyWidth-1:0] result_words_due[$];
   request_item_type    next_request;
   logic [KeyWidth-1:0] due_word;

   logic req_beat;
   int   req_gap;
   int   rsp_stall;
   bit   steady;
   int   hold_off_requests;
   int   hold_off_served;
   int   mismatches;

   always begin
      #5 clock = ~clock;
   end

   function automatic logic [WordWidth-1:0] keeloq_encipher(input logic [WordWidth-1:0] x,
                                                            input logic [KeyWidth-1:0] key);
      logic nb;
      int   r;
      for (r = 0; r < RoundsTotal; r++) begin
         nb = x[0] ^ x[16] ^ key[r & 63] ^ KlNlf[{x[31], x[26], x[20], x[9], x[1]}];
         x  = {nb, x[31:1]};
      end
      return x;
   endfunction

   function automatic logic [WordWidth-1:0] keeloq_decipher(input logic [WordWidth-1:0] x,
                                                            input logic [KeyWidth-1:0] key);
      logic nb;
      int   r;
      for (r = 0; r < RoundsTotal; r++) begin
         nb = x[31] ^ x[15] ^ key[(15 - r) & 63] ^ KlNlf[{x[30], x[25], x[19], x[8], x[0]}];
         x  = {x[30:0], nb};
      end
      return x;
   endfunction

   function automatic logic [KeyWidth-1:0] derived_key(input logic [WordWidth-1:0] fix,
                                                       input logic [WordWidth-1:0] seed);
      logic [WordWidth-1:0] f;
      logic [WordWidth-1:0] lo;
      logic [WordWidth-1:0] hi;
      logic [WordWidth-1:0] mix;
      f = fix & FixMask;
      case (learn_setting)
         LearnNormal, LearnAerf: begin
            lo = keeloq_decipher(f | PrefixLow, key_setting);
            hi = keeloq_decipher(f | PrefixHigh, key_setting);
            return {hi, lo};
         end
         LearnPujol: begin
            lo = keeloq_decipher(f | PrefixLow, key_setting);
            hi = keeloq_decipher(f | PrefixHigh, key_setting);
            return {hi[15:0], hi[31:16], lo[15:0], lo[31:16]};
         end
         LearnSecure: begin
            return {keeloq_decipher(f, key_setting), keeloq_decipher(seed, key_setting)};
         end
         LearnErreka: begin
            mix = ((seed >> 4) & MixDownMask) | ((seed << 4) & MixUpMask)
                  | (seed & MixKeepMask);
            lo  = keeloq_decipher(f | PrefixLow, key_setting);
            hi  = keeloq_decipher(mix | PrefixHigh, key_setting);
            return {hi, lo};
         end
         LearnXor1:    return {f, f} ^ key_setting;
         LearnSerial1: return {fix[23:0], 8'(fix[7:0] + fix[15:8]), key_setting[31:0]};
         LearnSerial2: return {fix[7:0], fix[15:8], fix[23:16], fix[31:24], key_setting[31:0]};
         LearnSerial3: return {key_setting[63:24], fix[23:0]};
         default:      return key_setting;
      endcase
   endfunction

   function automatic logic [KeyWidth-1:0] keeloq_result_word(input logic [1:0] func,
                                                              input logic [WordWidth-1:0] data,
                                                              input logic [WordWidth-1:0] seed);
      case (func)
         FuncEncrypt: return {32'b0, keeloq_encipher(data, key_setting)};
         FuncDecrypt: return {32'b0, keeloq_decipher(data, key_setting)};
         FuncDerive:  return derived_key(data, seed);
         default:     return '0;
      endcase
   endfunction

   // mostly back to back, sometimes a short gap, rarely a long pause
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic [WordWidth-1:0] random_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return FixMask;
         3:       return ~FixMask;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] random_func();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return FuncDerive;
      else if (r < 7)
         return FuncEncrypt;
      else if (r < 9)
         return FuncDecrypt;
      else
         return FuncUnused;
   endfunction

   function automatic logic [KeyWidth-1:0] random_key();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < MaxPrinted)
         $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic queue_request(input logic [1:0] func, input logic [WordWidth-1:0] data,
                                input logic [WordWidth-1:0] seed);
      request_item_type it;
      it.func      = func;
      it.data_word = data;
      it.seed_word = seed;
      requests_to_send.insert(requests_to_send.size(), it);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [KeyWidth-1:0] value);
      @(negedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= index;
      csr_if.wdata     <= value;
      do
         @(posedge clock);
      while (!csr_if.ready);
      if (index == CsrCipherKey)
         key_setting = value;
      else if (index == CsrLearningType)
         learn_setting = value[LearnWidth-1:0];
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // wait until every request is taken and every result is back;
   // look after the driver has settled for this falling edge
   task automatic drain();
      do begin
         @(negedge clock);
         #1;
      end while (requests_to_send.size() != 0 || req_if.valid || result_words_due.size() != 0);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap = 0;
      end else if (!req_if.valid || req_beat) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap--;
         end else if (requests_to_send.size() != 0) begin
            next_request = requests_to_send.pop_front();
            req_if.valid     <= 1'b1;
            req_if.func      <= next_request.func;
            req_if.data_word <= next_request.data_word;
            req_if.seed_word <= next_request.seed_word;
            if (!steady)
               req_gap = idle_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response backpressure; a hold-off request stalls the sink for a long stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (hold_off_requests != hold_off_served) begin
            hold_off_served = hold_off_requests;
            rsp_stall = HoldOffCycles;
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!steady)
               rsp_stall = idle_gap();
         end
      end
   end

   // monitor: predict on request beats, check on response beats
   always @(posedge clock) begin
      if (reset) begin
         req_beat <= 1'b0;
      end else begin
         req_beat <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready)
            result_words_due.insert(result_words_due.size(),
                                    keeloq_result_word(req_if.func, req_if.data_word,
                                                       req_if.seed_word));
         if (rsp_if.valid && rsp_if.ready) begin
            if (result_words_due.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing outstanding",
                                         rsp_if.result_word));
            end else begin
               due_word = result_words_due.pop_front();
               if (rsp_if.result_word !== due_word)
                  report_mismatch($sformatf("result_word %h, want %h",
                                            rsp_if.result_word, due_word));
            end
         end
      end
   end

   initial begin
      int                    phase;
      int                    n;
      int                    count;
      logic [LearnWidth-1:0] learn;

      clock             = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.func       = FuncEncrypt;
      req_if.data_word  = '0;
      req_if.seed_word  = '0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.reg_index  = CsrCipherKey;
      csr_if.wdata      = '0;
      key_setting       = '0;
      learn_setting     = '0;
      steady            = 1'b0;
      hold_off_requests = 0;
      hold_off_served   = 0;
      mismatches        = 0;
      req_gap           = 0;
      rsp_stall         = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers straight out of reset: zero key, learning type zero
      queue_request(FuncEncrypt, '0, '0);
      queue_request(FuncEncrypt, '1, '1);
      queue_request(FuncDecrypt, '0, '0);
      queue_request(FuncDecrypt, '1, '0);
      queue_request(FuncDerive, '1, '1);
      queue_request(FuncUnused, '1, '1);
      drain();

      write_register(CsrCipherKey, '1);
      write_register(CsrLearningType, {60'd0, LearnNormal});
      queue_request(FuncDerive, '0, '1);
      queue_request(FuncDerive, '1, '0);
      queue_request(FuncEncrypt, '1, '0);
      queue_request(FuncDecrypt, 32'h5A5A5A5A, '1);
      drain();

      write_register(CsrCipherKey, 64'h0123456789ABCDEF);
      write_register(CsrLearningType, {60'd0, LearnSecure});
      queue_request(FuncDerive, '1, '0);
      queue_request(FuncDerive, '0, '1);
      drain();
      write_register(CsrLearningType, {60'd0, LearnErreka});
      queue_request(FuncDerive, 32'h12345678, '1);
      queue_request(FuncDerive, 32'h12345678, 32'h0F0F0F0F);
      drain();
      write_register(CsrLearningType, {60'd0, LearnPujol});
      queue_request(FuncDerive, 32'h0ABCDEF0, '0);
      drain();

      for (phase = 0; phase < 32; phase++) begin
         steady = (phase == 0) || ($urandom_range(0, 3) == 0);
         write_register(CsrCipherKey, random_key());
         learn = (phase < 16) ? phase[3:0] : 4'($urandom_range(0, 15));
         // upper write bits carry noise; only the low nibble is kept
         write_register(CsrLearningType, {$urandom, 28'($urandom), learn});
         if (phase % 8 == 3)
            write_register(CsrNoRegister, {$urandom, $urandom});
         count = (phase == 0) ? 150 : 35;
         for (n = 0; n < count; n++)
            queue_request(random_func(), random_word(), random_word());
         // stall the sink long enough for the round chain to back up
         if (phase == 0 || phase == 20)
            hold_off_requests++;
         drain();
      end

      repeat (80) @(negedge clock);
      if (mismatches == 0 && result_words_due.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
